// ===== rtl/core/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and constants for the go-back-n sender window.
// ----------------------------------------------------------------------------
package gbn_pkg;

    // field widths of the request and result
    localparam int OPCODE_W      = 2;
    localparam int FIELD_W       = 5;
    // widest sequence number the parameters allow (256 entries)
    localparam int MAX_NUM_W     = 8;

    // default window configuration
    localparam int SEQ_SPACE_DEF = 32;
    localparam int WINDOW_DEF    = 16;

    // request operations
    typedef enum logic [OPCODE_W-1:0] {
        OP_SEND    = 2'd0,
        OP_ACK     = 2'd1,
        OP_TIMEOUT = 2'd2
    } t_opcode;

    // one request as held in the input register
    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [FIELD_W-1:0]  ack_number;
    } t_item;

    // one result as held in the output register
    typedef struct packed {
        logic               send_granted;
        logic [FIELD_W-1:0] send_number;
        logic [FIELD_W-1:0] window_base;
        logic [FIELD_W-1:0] in_flight;
    } t_result;

endpackage

// ===== rtl/core/gbn_in_stage.sv =====
// ----------------------------------------------------------------------------
// gbn_in_stage
// Input register: captures one request and holds it until the window
// logic moves it on.
// ----------------------------------------------------------------------------
module gbn_in_stage
    import gbn_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [FIELD_W-1:0]  i_ack_number,
    input  logic                i_advance,
    output logic                o_valid,
    output t_item               o_item
);

    logic  r_valid;
    t_item r_item;

    // free when empty or when the held request moves on this cycle
    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // request payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item.opcode     <= i_opcode;
            r_item.ack_number <= i_ack_number;
        end
    end

endmodule

// ===== rtl/core/gbn_window_core.sv =====
// ----------------------------------------------------------------------------
// gbn_window_core
// Window state (next number, base, free bitmap) and the single-pass
// update for one request, with the result it produces.
// ----------------------------------------------------------------------------
module gbn_window_core
    import gbn_pkg::*;
#(
    parameter int SEQ_SPACE = SEQ_SPACE_DEF,
    parameter int WINDOW    = WINDOW_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    output t_result o_result
);

    localparam int NUM_W    = $clog2(SEQ_SPACE);
    localparam int ACK_SPAN = 1 << FIELD_W;
    localparam logic [MAX_NUM_W-1:0] WIN_L = MAX_NUM_W'(WINDOW);

    logic [NUM_W-1:0]     r_next;
    logic [NUM_W-1:0]     r_base;
    logic [SEQ_SPACE-1:0] r_free;

    logic [NUM_W-1:0]     n_next;
    logic [NUM_W-1:0]     n_base;
    logic [SEQ_SPACE-1:0] n_free;

    logic [NUM_W-1:0]     w_ack_tab [ACK_SPAN];
    logic [NUM_W-1:0]     w_ack;
    logic [NUM_W-1:0]     w_ack_off;
    logic [NUM_W-1:0]     w_dist;
    logic [SEQ_SPACE-1:0] w_ack_mask;
    logic [SEQ_SPACE-1:0] w_tmo_mask;
    logic                 w_granted;
    logic [NUM_W-1:0]     w_number;

    // circular distance from b forward to a
    function automatic logic [NUM_W-1:0] f_dist(
        input logic [NUM_W-1:0] a,
        input logic [NUM_W-1:0] b
    );
        logic [NUM_W:0] sum;
        sum = {1'b0, a} + (NUM_W+1)'(SEQ_SPACE) - {1'b0, b};
        if (a >= b) begin
            return a - b;
        end
        return sum[NUM_W-1:0];
    endfunction

    // next number around the sequence space
    function automatic logic [NUM_W-1:0] f_inc(input logic [NUM_W-1:0] v);
        if (v == NUM_W'(SEQ_SPACE - 1)) begin
            return '0;
        end
        return v + 1'b1;
    endfunction

    // fit a sequence number to the result field
    function automatic logic [FIELD_W-1:0] f_field(input logic [NUM_W-1:0] v);
        logic [MAX_NUM_W-1:0] wide;
        wide = MAX_NUM_W'(v);
        return wide[FIELD_W-1:0];
    endfunction

    // ack number reduced into the sequence space
    for (genvar k = 0; k < ACK_SPAN; k++) begin : g_ack_tab
        assign w_ack_tab[k] = NUM_W'(k % SEQ_SPACE);
    end

    assign w_ack     = w_ack_tab[i_item.ack_number];
    assign w_ack_off = f_dist(w_ack, r_base);
    assign w_dist    = f_dist(r_next, r_base);

    // per-number span masks for ack and timeout
    for (genvar j = 0; j < SEQ_SPACE; j++) begin : g_mask
        logic [NUM_W-1:0] w_off;
        assign w_off         = f_dist(NUM_W'(j), r_base);
        assign w_ack_mask[j] = (w_off <= w_ack_off);
        assign w_tmo_mask[j] = (MAX_NUM_W'(w_off) < WIN_L);
    end

    // next state for the request at hand
    always_comb begin
        n_next    = r_next;
        n_base    = r_base;
        n_free    = r_free;
        w_granted = 1'b0;
        w_number  = '0;
        case (t_opcode'(i_item.opcode))
            OP_SEND: begin
                if ((MAX_NUM_W'(w_dist) < WIN_L) && r_free[r_next]) begin
                    w_granted      = 1'b1;
                    w_number       = r_next;
                    n_free[r_next] = 1'b0;
                    n_next         = f_inc(r_next);
                end
            end
            OP_ACK: begin
                n_free = r_free | w_ack_mask;
                n_base = f_inc(w_ack);
            end
            OP_TIMEOUT: begin
                n_free = r_free | w_tmo_mask;
                n_next = r_base;
            end
            default: begin
                n_next = r_next;
            end
        endcase
    end

    // result reflects the state after the request
    assign o_result.send_granted = w_granted;
    assign o_result.send_number  = f_field(w_number);
    assign o_result.window_base  = f_field(n_base);
    assign o_result.in_flight    = f_field(f_dist(n_next, n_base));

    // window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next <= '0;
            r_base <= '0;
            r_free <= '1;
        end else if (i_fire) begin
            r_next <= n_next;
            r_base <= n_base;
            r_free <= n_free;
        end
    end

endmodule

// ===== rtl/core/gbn_out_stage.sv =====
// ----------------------------------------------------------------------------
// gbn_out_stage
// Output register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module gbn_out_stage
    import gbn_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_result,
    output logic    o_advance,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // room when empty or when the held result leaves this cycle
    assign o_advance = !r_valid || i_ready;
    assign o_valid   = r_valid;
    assign o_result  = r_result;

    // occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_advance) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== rtl/core/go_back_n_sender_window.sv =====
// ----------------------------------------------------------------------------
// go_back_n_sender_window
// Sender side of a go-back-n sliding window over numbers 0..SEQ_SPACE-1.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (i_valid / o_ready) carries an opcode (send, ack,
//   timeout) and a cumulative ack number. Each request yields exactly one
//   result on the result channel (o_valid / i_ready): the grant flag, the
//   granted number, the window base and the in-flight count after it.
//   An accepted request goes through the input register, then the window
//   update, which writes the output register. Throughput is one request per
//   cycle while the receiver does not stall; the window logic is a single
//   pass over the number/base pointers and a SEQ_SPACE-bit free bitmap.
//   When the receiver stalls, the result holds in the output register and
//   one more request waits in the input register; o_ready then drops.
//   Reset clears both pointers to zero, marks every number free in the
//   same cycle and empties both registers.
// ----------------------------------------------------------------------------
module go_back_n_sender_window
    import gbn_pkg::*;
#(
    parameter int SEQ_SPACE = SEQ_SPACE_DEF,
    parameter int WINDOW    = WINDOW_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [FIELD_W-1:0]  i_ack_number,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_send_granted,
    output logic [FIELD_W-1:0]  o_send_number,
    output logic [FIELD_W-1:0]  o_window_base,
    output logic [FIELD_W-1:0]  o_in_flight
);

    logic    w_in_valid;
    t_item   w_item;
    logic    w_advance;
    t_result w_result;
    t_result w_out;

    // input register
    gbn_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_opcode     (i_opcode),
        .i_ack_number (i_ack_number),
        .i_advance    (w_advance),
        .o_valid      (w_in_valid),
        .o_item       (w_item)
    );

    // window state and update
    gbn_window_core #(
        .SEQ_SPACE (SEQ_SPACE),
        .WINDOW    (WINDOW)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_in_valid && w_advance),
        .i_item   (w_item),
        .o_result (w_result)
    );

    // output register
    gbn_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_in_valid),
        .i_result  (w_result),
        .o_advance (w_advance),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_result  (w_out)
    );

    assign o_send_granted = w_out.send_granted;
    assign o_send_number  = w_out.send_number;
    assign o_window_base  = w_out.window_base;
    assign o_in_flight    = w_out.in_flight;

`ifndef SYNTHESIS
    // a refused or non-send result carries number zero
    a_no_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_send_granted) |-> (o_send_number == '0))
        else $error("send number set without a grant");

    // an accepted request lands in the input register
    a_accept_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> w_in_valid)
        else $error("accepted request lost");

    // a stalled request waits unchanged between the two registers
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_valid && !w_advance) |=> (w_in_valid && $stable(w_item)))
        else $error("stalled request changed");
`endif

endmodule
